@@ hw/rtl/tlik_pkg.sv @@
// shared types, constants and the cordic angle table of the two-link ik unit
`timescale 1ns / 1ps
package tlik_pkg;

   localparam int COORD_W  = 16;
   localparam int LINK_W   = 14;
   localparam int ANGLE_W  = 16;
   localparam int CHOICE_W = 2;
   localparam int INDEX_W  = 2;

   localparam int SQ_W      = 32;              // x*x and y*y; d^2 takes one bit more
   localparam int LINK_SQ_W = 2 * LINK_W;      // l1*l1, l1*l2
   localparam int SUM_SQ_W  = 2 * (LINK_W + 1);
   localparam int NUM_W     = SQ_W + 2;
   localparam int DEN_W     = LINK_SQ_W + 1;   // 2*l1*l2
   localparam int DIV_BITS  = 14;
   localparam int CMAG_W    = DIV_BITS + 1;
   localparam int C_W       = CMAG_W + 1;
   localparam int RAD_W     = 2 * DIV_BITS + 1;
   localparam int SQRT_BITS = DIV_BITS + 1;
   localparam int CV_W      = 34;              // cordic vector width
   localparam int ZW        = 28;              // angle, degrees Q.16
   localparam int ROUND_SHIFT = 9;

   localparam int CORDIC_ITERATIONS = 16;
   localparam int ATAN_TABLE_LEN    = 24;
   localparam int CORDIC_STEPS =
      (CORDIC_ITERATIONS > ATAN_TABLE_LEN) ? ATAN_TABLE_LEN : CORDIC_ITERATIONS;

   localparam logic [CMAG_W-1:0] ONE_Q14 = CMAG_W'(16384);
   localparam logic [RAD_W-1:0]  ONE_SQ  = RAD_W'(268435456);
   localparam logic signed [ZW-1:0] DEG180 = ZW'(11796480);
   localparam logic signed [ZW-1:0] DEG360 = ZW'(23592960);
   localparam logic signed [ZW-1:0] DEG540 = ZW'(35389440);
   localparam logic signed [ZW-1:0] DEG720 = ZW'(47185920);

   localparam logic [CHOICE_W-1:0] CHOICE_UP   = 2'd1;
   localparam logic [CHOICE_W-1:0] CHOICE_DOWN = 2'd2;

   localparam logic [INDEX_W-1:0] REG_FIRST_LINK  = 2'd0;
   localparam logic [INDEX_W-1:0] REG_SECOND_LINK = 2'd1;
   localparam logic [INDEX_W-1:0] REG_SHOULDER    = 2'd2;
   localparam logic [INDEX_W-1:0] REG_ELBOW       = 2'd3;

   localparam logic [LINK_W-1:0]  FIRST_LINK_RESET  = 14'd3584;
   localparam logic [LINK_W-1:0]  SECOND_LINK_RESET = 14'd4506;
   localparam logic [ANGLE_W-1:0] SHOULDER_RESET    = 16'd1792;
   localparam logic [ANGLE_W-1:0] ELBOW_RESET       = 16'd3200;

   typedef enum logic [1:0] {
      STATUS_SOLVED    = 2'd0,
      STATUS_TOO_FAR   = 2'd1,
      STATUS_TOO_CLOSE = 2'd2
   } status_type;

   // what travels beside the arithmetic through the pipeline
   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic                      up;
      status_type                status;
      logic                      sat;
      logic                      neg;
      logic signed [C_W-1:0]     c;
   } item_type;

   // atan(2^-i) in degrees Q.16, rounded
   function automatic logic signed [ZW-1:0] atan_entry(input int idx);
      logic signed [ZW-1:0] val;
      case (idx)
         0: val = ZW'(2949120);
         1: val = ZW'(1740967);
         2: val = ZW'(919879);
         3: val = ZW'(466945);
         4: val = ZW'(234379);
         5: val = ZW'(117304);
         6: val = ZW'(58666);
         7: val = ZW'(29335);
         8: val = ZW'(14668);
         9: val = ZW'(7334);
         10: val = ZW'(3667);
         11: val = ZW'(1833);
         12: val = ZW'(917);
         13: val = ZW'(458);
         14: val = ZW'(229);
         15: val = ZW'(115);
         16: val = ZW'(57);
         17: val = ZW'(29);
         18: val = ZW'(14);
         19: val = ZW'(7);
         20: val = ZW'(4);
         21: val = ZW'(2);
         22: val = ZW'(1);
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

@@ hw/rtl/tlik_div.sv @@
// pipelined restoring divider for the elbow cosine fraction, one bit per stage
`timescale 1ns / 1ps
module tlik_div import tlik_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic [DEN_W-1:0]    in_mag,
   input  logic [DEN_W-1:0]    in_den,
   input  item_type            in_side,
   output logic                out_valid,
   output logic [DIV_BITS-1:0] out_quot,
   output item_type            out_side
);

   logic [DIV_BITS-1:0] valid_ff;
   logic [DEN_W-1:0]    rem_ff  [DIV_BITS];
   logic [DIV_BITS-1:0] quot_ff [DIV_BITS];
   item_type            side_ff [DIV_BITS];

   for (genvar k = 0; k < DIV_BITS; k++) begin : g_stage
      logic                valid_prev;
      logic [DEN_W-1:0]    rem_prev;
      logic [DIV_BITS-1:0] quot_prev;
      item_type            side_prev;
      logic [DEN_W:0]      twice;
      logic                fits;
      logic [DEN_W-1:0]    rem_in;
      logic [DIV_BITS-1:0] quot_in;

      if (k == 0) begin : g_first
         assign valid_prev = in_valid;
         assign rem_prev   = in_mag;
         assign quot_prev  = '0;
         assign side_prev  = in_side;
      end else begin : g_next
         assign valid_prev = valid_ff[k-1];
         assign rem_prev   = rem_ff[k-1];
         assign quot_prev  = quot_ff[k-1];
         assign side_prev  = side_ff[k-1];
      end

      assign twice   = {rem_prev, 1'b0};
      assign fits    = twice >= {1'b0, in_den};
      assign rem_in  = fits ? DEN_W'(twice - {1'b0, in_den}) : twice[DEN_W-1:0];
      assign quot_in = {quot_prev[DIV_BITS-2:0], fits};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k]  <= rem_in;
         quot_ff[k] <= quot_in;
         side_ff[k] <= side_prev;
      end
   end

   assign out_valid = valid_ff[DIV_BITS-1];
   assign out_quot  = quot_ff[DIV_BITS-1];
   assign out_side  = side_ff[DIV_BITS-1];

endmodule

@@ hw/rtl/tlik_sqrt.sv @@
// pipelined integer square root for the elbow sine, one root bit per stage
`timescale 1ns / 1ps
module tlik_sqrt import tlik_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [RAD_W-1:0]     in_rad,
   input  item_type             in_side,
   output logic                 out_valid,
   output logic [SQRT_BITS-1:0] out_root,
   output item_type             out_side
);

   localparam int T_W = 2 * SQRT_BITS + 1;

   logic [SQRT_BITS-1:0] valid_ff;
   logic [RAD_W-1:0]     rem_ff  [SQRT_BITS];
   logic [SQRT_BITS-1:0] root_ff [SQRT_BITS];
   item_type             side_ff [SQRT_BITS];

   for (genvar k = 0; k < SQRT_BITS; k++) begin : g_stage
      localparam int B = SQRT_BITS - 1 - k;
      logic                 valid_prev;
      logic [RAD_W-1:0]     rem_prev;
      logic [SQRT_BITS-1:0] root_prev;
      item_type             side_prev;
      logic [T_W-1:0]       trial;
      logic                 fits;
      logic [RAD_W-1:0]     rem_in;
      logic [SQRT_BITS-1:0] root_in;

      if (k == 0) begin : g_first
         assign valid_prev = in_valid;
         assign rem_prev   = in_rad;
         assign root_prev  = '0;
         assign side_prev  = in_side;
      end else begin : g_next
         assign valid_prev = valid_ff[k-1];
         assign rem_prev   = rem_ff[k-1];
         assign root_prev  = root_ff[k-1];
         assign side_prev  = side_ff[k-1];
      end

      // (2r + 2^b) * 2^b with r holding only bits above b
      assign trial   = (T_W'(root_prev) << (B + 1)) | (T_W'(1) << (2 * B));
      assign fits    = trial <= T_W'(rem_prev);
      assign rem_in  = fits ? RAD_W'(T_W'(rem_prev) - trial) : rem_prev;
      assign root_in = fits ? (root_prev | (SQRT_BITS'(1) << B)) : root_prev;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k]  <= rem_in;
         root_ff[k] <= root_in;
         side_ff[k] <= side_prev;
      end
   end

   assign out_valid = valid_ff[SQRT_BITS-1];
   assign out_root  = root_ff[SQRT_BITS-1];
   assign out_side  = side_ff[SQRT_BITS-1];

endmodule

@@ hw/rtl/tlik_cordic.sv @@
// pipelined vectoring cordic giving atan2(y, x) in degrees Q.16
`timescale 1ns / 1ps
module tlik_cordic import tlik_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic signed [CV_W-1:0] in_x,
   input  logic signed [CV_W-1:0] in_y,
   input  item_type               in_side,
   output logic                   out_valid,
   output logic signed [ZW-1:0]   out_angle,
   output item_type               out_side
);

   logic [CORDIC_STEPS:0]  valid_ff;
   logic signed [CV_W-1:0] x_ff    [CORDIC_STEPS+1];
   logic signed [CV_W-1:0] y_ff    [CORDIC_STEPS+1];
   logic signed [ZW-1:0]   z_ff    [CORDIC_STEPS+1];
   logic                   zero_ff [CORDIC_STEPS+1];
   item_type               side_ff [CORDIC_STEPS+1];

   logic                   flip;
   logic signed [CV_W-1:0] x_in;
   logic signed [CV_W-1:0] y_in;
   logic signed [ZW-1:0]   z_in;

   // left half plane: turn by 180 degrees first
   always_comb begin
      flip = in_x < 0;
      x_in = flip ? -in_x : in_x;
      y_in = flip ? -in_y : in_y;
      if (!flip) begin
         z_in = '0;
      end else if (in_y >= 0) begin
         z_in = DEG180;
      end else begin
         z_in = -DEG180;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      x_ff[0]    <= x_in;
      y_ff[0]    <= y_in;
      z_ff[0]    <= z_in;
      zero_ff[0] <= (in_x == 0) && (in_y == 0);
      side_ff[0] <= in_side;
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      logic signed [CV_W-1:0] dx;
      logic signed [CV_W-1:0] dy;
      logic signed [CV_W-1:0] xs_in;
      logic signed [CV_W-1:0] ys_in;
      logic signed [ZW-1:0]   zs_in;

      assign dx = x_ff[i] >>> i;
      assign dy = y_ff[i] >>> i;

      always_comb begin
         if (y_ff[i] >= 0) begin
            xs_in = x_ff[i] + dy;
            ys_in = y_ff[i] - dx;
            zs_in = z_ff[i] + atan_entry(i);
         end else begin
            xs_in = x_ff[i] - dy;
            ys_in = y_ff[i] + dx;
            zs_in = z_ff[i] - atan_entry(i);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i+1] <= 1'b0;
         end else begin
            valid_ff[i+1] <= valid_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         x_ff[i+1]    <= xs_in;
         y_ff[i+1]    <= ys_in;
         z_ff[i+1]    <= zs_in;
         zero_ff[i+1] <= zero_ff[i];
         side_ff[i+1] <= side_ff[i];
      end
   end

   assign out_valid = valid_ff[CORDIC_STEPS];
   assign out_angle = zero_ff[CORDIC_STEPS] ? '0 : z_ff[CORDIC_STEPS];
   assign out_side  = side_ff[CORDIC_STEPS];

endmodule

@@ hw/rtl/two_link_inverse_kinematics_unit.sv @@
// top level of the two-link planar inverse kinematics pipeline
//
// A target beat (req_target_x, req_target_y in Q5.10, req_elbow_choice) is
// taken at each rising edge with start high; busy stays low, so a new target
// may follow in every cycle. Each target gives one result beat: rsp_valid is
// high for one cycle with rsp_shoulder_angle, rsp_elbow_angle (degrees, Q9.7)
// and rsp_status (solved, too far, too close; angles zero unless solved).
// A target passes reach check and cosine setup, the restoring divider
// (14 stages), cosine square, the square root (15 stages), link products,
// three cordic units side by side and angle combine, wrap and output.
// Throughput is one target per cycle. The receiver cannot stall; every
// result appears once, in order. Link lengths and offsets must be written
// on the csr_ port only while no target is in flight; the block itself
// does not enforce this. Synchronous reset drops all beats in flight and
// loads the default link lengths and offsets.
`timescale 1ns / 1ps
module two_link_inverse_kinematics_unit import tlik_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic signed [COORD_W-1:0] req_target_x,
   input  logic signed [COORD_W-1:0] req_target_y,
   input  logic [CHOICE_W-1:0]       req_elbow_choice,
   output logic                      rsp_valid,
   output logic signed [ANGLE_W-1:0] rsp_shoulder_angle,
   output logic signed [ANGLE_W-1:0] rsp_elbow_angle,
   output logic [1:0]                rsp_status,
   input  logic                      csr_we,
   input  logic [INDEX_W-1:0]        csr_index,
   input  logic [ANGLE_W-1:0]        csr_wdata
);

   localparam int WIDE_W = ZW - ROUND_SHIFT + 2;

   function automatic logic signed [ANGLE_W-1:0] to_output(
      input logic signed [ZW-1:0]      deg,
      input logic signed [ANGLE_W-1:0] offset
   );
      logic signed [ZW-1:0]     rounded;
      logic signed [WIDE_W-1:0] wide;
      logic signed [ANGLE_W-1:0] res;
      rounded = deg + ZW'(256);
      wide = WIDE_W'($signed(rounded[ZW-1:ROUND_SHIFT])) - WIDE_W'(offset);
      if (wide > WIDE_W'(32767)) begin
         res = ANGLE_W'(32767);
      end else if (wide < -WIDE_W'(32768)) begin
         res = ANGLE_W'(-32768);
      end else begin
         res = ANGLE_W'(wide);
      end
      return res;
   endfunction

   // configuration registers
   logic [LINK_W-1:0]         l1_ff;
   logic [LINK_W-1:0]         l2_ff;
   logic signed [ANGLE_W-1:0] sh_off_ff;
   logic signed [ANGLE_W-1:0] el_off_ff;
   logic [DEN_W-1:0]          den_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         l1_ff     <= FIRST_LINK_RESET;
         l2_ff     <= SECOND_LINK_RESET;
         sh_off_ff <= SHOULDER_RESET;
         el_off_ff <= ELBOW_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_FIRST_LINK:  l1_ff     <= csr_wdata[LINK_W-1:0];
            REG_SECOND_LINK: l2_ff     <= csr_wdata[LINK_W-1:0];
            REG_SHOULDER:    sh_off_ff <= csr_wdata;
            REG_ELBOW:       el_off_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   logic [LINK_SQ_W-1:0] l1l2;
   assign l1l2 = l1_ff * l2_ff;

   always_ff @(posedge clock) begin
      den_ff <= {l1l2, 1'b0};
   end

   // stage a: squares
   logic                      a_valid_ff;
   logic signed [COORD_W-1:0] a_x_ff;
   logic signed [COORD_W-1:0] a_y_ff;
   logic                      a_up_ff;
   logic [SQ_W-1:0]           a_xx_ff;
   logic [SQ_W-1:0]           a_yy_ff;
   logic [LINK_SQ_W-1:0]      a_l1l1_ff;
   logic [LINK_SQ_W-1:0]      a_l2l2_ff;
   logic [SUM_SQ_W-1:0]       a_sum2_ff;
   logic [LINK_SQ_W-1:0]      a_diff2_ff;
   logic                      a_den_zero_ff;

   logic                      up_in;
   logic signed [SQ_W-1:0]    xx_in;
   logic signed [SQ_W-1:0]    yy_in;
   logic [LINK_W:0]           sum_in;
   logic [LINK_W-1:0]         diff_in;

   always_comb begin
      if (req_elbow_choice == CHOICE_UP) begin
         up_in = 1'b1;
      end else if (req_elbow_choice == CHOICE_DOWN) begin
         up_in = 1'b0;
      end else begin
         up_in = req_target_y < 0;
      end
      xx_in   = req_target_x * req_target_x;
      yy_in   = req_target_y * req_target_y;
      sum_in  = {1'b0, l1_ff} + {1'b0, l2_ff};
      diff_in = (l1_ff > l2_ff) ? l1_ff - l2_ff : l2_ff - l1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      a_x_ff        <= req_target_x;
      a_y_ff        <= req_target_y;
      a_up_ff       <= up_in;
      a_xx_ff       <= SQ_W'(xx_in);
      a_yy_ff       <= SQ_W'(yy_in);
      a_l1l1_ff     <= l1_ff * l1_ff;
      a_l2l2_ff     <= l2_ff * l2_ff;
      a_sum2_ff     <= sum_in * sum_in;
      a_diff2_ff    <= diff_in * diff_in;
      a_den_zero_ff <= l1l2 == '0;
   end

   // stage b: distance, reach check, cosine numerator
   logic                     b_valid_ff;
   logic signed [NUM_W-1:0]  b_num_ff;
   logic                     b_den_zero_ff;
   item_type                 b_side_ff;
   logic [SQ_W:0]            d2_in;
   status_type               status_in;

   always_comb begin
      d2_in = {1'b0, a_xx_ff} + {1'b0, a_yy_ff};
      if (d2_in > (SQ_W + 1)'(a_sum2_ff)) begin
         status_in = STATUS_TOO_FAR;
      end else if (d2_in < (SQ_W + 1)'(a_diff2_ff)) begin
         status_in = STATUS_TOO_CLOSE;
      end else begin
         status_in = STATUS_SOLVED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      b_num_ff <= NUM_W'(d2_in) - NUM_W'(a_l1l1_ff) - NUM_W'(a_l2l2_ff);
      b_den_zero_ff    <= a_den_zero_ff;
      b_side_ff.x      <= a_x_ff;
      b_side_ff.y      <= a_y_ff;
      b_side_ff.up     <= a_up_ff;
      b_side_ff.status <= status_in;
      b_side_ff.sat    <= 1'b0;
      b_side_ff.neg    <= 1'b0;
      b_side_ff.c      <= '0;
   end

   // stage c: magnitude and saturation test ahead of the divider
   logic             c_valid_ff;
   logic [DEN_W-1:0] c_mag_ff;
   item_type         c_side_ff;
   logic [NUM_W-1:0] mag_in;
   item_type         cside_in;

   always_comb begin
      mag_in       = (b_num_ff < 0) ? NUM_W'(-b_num_ff) : NUM_W'(b_num_ff);
      cside_in     = b_side_ff;
      // quotient would reach one: clamp, and zero links give plus one
      cside_in.sat = b_den_zero_ff || (mag_in >= NUM_W'(den_ff));
      cside_in.neg = !b_den_zero_ff && (b_num_ff < 0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      c_mag_ff  <= mag_in[DEN_W-1:0];
      c_side_ff <= cside_in;
   end

   logic                dv_valid;
   logic [DIV_BITS-1:0] dv_quot;
   item_type            dv_side;

   tlik_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (c_valid_ff),
      .in_mag    (c_mag_ff),
      .in_den    (den_ff),
      .in_side   (c_side_ff),
      .out_valid (dv_valid),
      .out_quot  (dv_quot),
      .out_side  (dv_side)
   );

   // stage d: signed cosine and 1 - c^2
   logic             d_valid_ff;
   logic [RAD_W-1:0] d_rad_ff;
   item_type         d_side_ff;
   logic [CMAG_W-1:0]   cmag_in;
   logic [2*CMAG_W-1:0] csq_in;
   item_type            dside_in;

   always_comb begin
      cmag_in    = dv_side.sat ? ONE_Q14 : {1'b0, dv_quot};
      csq_in     = cmag_in * cmag_in;
      dside_in   = dv_side;
      dside_in.c = dv_side.neg ? -C_W'(cmag_in) : C_W'(cmag_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else begin
         d_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      d_rad_ff  <= ONE_SQ - RAD_W'(csq_in);
      d_side_ff <= dside_in;
   end

   logic                 sq_valid;
   logic [SQRT_BITS-1:0] sq_root;
   item_type             sq_side;

   tlik_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (d_valid_ff),
      .in_rad    (d_rad_ff),
      .in_side   (d_side_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   // stage e: link products and cordic operands
   logic                   e_valid_ff;
   logic signed [CV_W-1:0] e_ex_ff;
   logic signed [CV_W-1:0] e_ey_ff;
   logic signed [CV_W-1:0] e_tx_ff;
   logic signed [CV_W-1:0] e_ty_ff;
   logic signed [CV_W-1:0] e_k1_ff;
   logic signed [CV_W-1:0] e_k2_ff;
   item_type               e_side_ff;
   logic signed [CV_W-1:0] k1_in;
   logic signed [CV_W-1:0] k2_in;

   always_comb begin
      k1_in = (CV_W'($signed({1'b0, l1_ff})) <<< DIV_BITS)
            + CV_W'($signed({1'b0, l2_ff}) * sq_side.c);
      k2_in = CV_W'($signed({1'b0, l2_ff}) * $signed({1'b0, sq_root}));
      if (!sq_side.up) begin
         k2_in = -k2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else begin
         e_valid_ff <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      e_ex_ff   <= CV_W'(sq_side.c) <<< 10;
      e_ey_ff   <= CV_W'($signed({1'b0, sq_root})) <<< 10;
      e_tx_ff   <= CV_W'(sq_side.x) <<< DIV_BITS;
      e_ty_ff   <= CV_W'(sq_side.y) <<< DIV_BITS;
      e_k1_ff   <= k1_in;
      e_k2_ff   <= k2_in;
      e_side_ff <= sq_side;
   end

   logic                 cr_valid;
   logic signed [ZW-1:0] z_elbow;
   logic signed [ZW-1:0] z_target;
   logic signed [ZW-1:0] z_link;
   item_type             cr_side;

   tlik_cordic u_cordic_target (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (e_valid_ff),
      .in_x      (e_tx_ff),
      .in_y      (e_ty_ff),
      .in_side   (e_side_ff),
      .out_valid (cr_valid),
      .out_angle (z_target),
      .out_side  (cr_side)
   );

   tlik_cordic u_cordic_elbow (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (e_valid_ff),
      .in_x      (e_ex_ff),
      .in_y      (e_ey_ff),
      .in_side   (e_side_ff),
      .out_valid (),
      .out_angle (z_elbow),
      .out_side  ()
   );

   tlik_cordic u_cordic_link (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (e_valid_ff),
      .in_x      (e_k1_ff),
      .in_y      (e_k2_ff),
      .in_side   (e_side_ff),
      .out_valid (),
      .out_angle (z_link),
      .out_side  ()
   );

   // stage f: shoulder difference, elbow sign
   logic                 f_valid_ff;
   logic signed [ZW-1:0] f_q1_ff;
   logic signed [ZW-1:0] f_q2_ff;
   status_type           f_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else begin
         f_valid_ff <= cr_valid;
      end
   end

   always_ff @(posedge clock) begin
      f_q1_ff     <= z_target - z_link;
      f_q2_ff     <= cr_side.up ? z_elbow : -z_elbow;
      f_status_ff <= cr_side.status;
   end

   // stage g: wrap shoulder into (-180, 180]
   logic                 g_valid_ff;
   logic signed [ZW-1:0] g_q1_ff;
   logic signed [ZW-1:0] g_q2_ff;
   status_type           g_status_ff;
   logic signed [ZW-1:0] q1_in;

   always_comb begin
      priority if (f_q1_ff > DEG540) begin
         q1_in = f_q1_ff - DEG720;
      end else if (f_q1_ff > DEG180) begin
         q1_in = f_q1_ff - DEG360;
      end else if (f_q1_ff <= -DEG540) begin
         q1_in = f_q1_ff + DEG720;
      end else if (f_q1_ff <= -DEG180) begin
         q1_in = f_q1_ff + DEG360;
      end else begin
         q1_in = f_q1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         g_valid_ff <= 1'b0;
      end else begin
         g_valid_ff <= f_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      g_q1_ff     <= q1_in;
      g_q2_ff     <= f_q2_ff;
      g_status_ff <= f_status_ff;
   end

   // stage h: round, offset, saturate
   logic                      rsp_valid_ff;
   logic signed [ANGLE_W-1:0] rsp_shoulder_ff;
   logic signed [ANGLE_W-1:0] rsp_elbow_ff;
   status_type                rsp_status_ff;
   logic                      solved;

   assign solved = g_status_ff == STATUS_SOLVED;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= g_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_shoulder_ff <= solved ? to_output(g_q1_ff, sh_off_ff) : '0;
      rsp_elbow_ff    <= solved ? to_output(g_q2_ff, el_off_ff) : '0;
      rsp_status_ff   <= g_status_ff;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_shoulder_angle = rsp_shoulder_ff;
   assign rsp_elbow_angle    = rsp_elbow_ff;
   assign rsp_status         = rsp_status_ff;

endmodule

@@ verif/two_link_inverse_kinematics_unit_checker.sv @@
// checker of the two-link ik unit: predicts each result and compares it with the rsp_ beats
`timescale 1ns / 1ps
module two_link_inverse_kinematics_unit_checker import tlik_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      busy,
   input  logic signed [COORD_W-1:0] req_target_x,
   input  logic signed [COORD_W-1:0] req_target_y,
   input  logic [CHOICE_W-1:0]       req_elbow_choice,
   input  logic                      rsp_valid,
   input  logic signed [ANGLE_W-1:0] rsp_shoulder_angle,
   input  logic signed [ANGLE_W-1:0] rsp_elbow_angle,
   input  logic [1:0]                rsp_status,
   input  logic                      csr_we,
   input  logic [INDEX_W-1:0]        csr_index,
   input  logic [ANGLE_W-1:0]        csr_wdata,
   output int                        fail_count,
   output int                        pending_count
);

   typedef struct packed {
      logic signed [ANGLE_W-1:0] shoulder;
      logic signed [ANGLE_W-1:0] elbow;
      status_type                status;
   } joint_cmd_type;

   localparam longint HALF_TURN = 64'sd11796480;
   localparam longint FULL_TURN = 64'sd23592960;
   localparam longint UNIT_C    = 64'sd16384;

   longint arctan_deg[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
      29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};

   logic [LINK_W-1:0]         link_a, link_b;
   logic signed [ANGLE_W-1:0] offs_shoulder, offs_elbow;
   joint_cmd_type             cmd_queue[$];

   function automatic longint isqrt(longint v);
      longint r, b;
      r = 0;
      b = 64'sd1 << 60;
      while (b > v) b = b >>> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >>> 1) + b;
         end else begin
            r = r >>> 1;
         end
         b = b >>> 2;
      end
      return r;
   endfunction

   // vectoring cordic, degrees in Q.16
   function automatic longint vector_angle(longint y, longint x);
      longint z, dx, dy;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         z = (y >= 0) ? HALF_TURN : -HALF_TURN;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = x >>> i;
         dy = y >>> i;
         if (y >= 0) begin
            x += dy; y -= dx; z += arctan_deg[i];
         end else begin
            x -= dy; y += dx; z -= arctan_deg[i];
         end
      end
      return z;
   endfunction

   function automatic logic signed [ANGLE_W-1:0] joint_out(longint deg, longint offs);
      longint v;
      v = ((deg + 256) >>> 9) - offs;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return ANGLE_W'(v);
   endfunction

   function automatic joint_cmd_type solve_joints(longint x, longint y, logic [1:0] ch);
      joint_cmd_type r;
      longint l1, l2, d2, sum, diff, den, num, mag, q, c, s, k1, k2, q1, q2;
      logic up;
      l1 = link_a;
      l2 = link_b;
      d2 = x * x + y * y;
      sum = l1 + l2;
      diff = (l1 > l2) ? l1 - l2 : l2 - l1;
      r = '0;
      if (d2 > sum * sum) begin
         r.status = STATUS_TOO_FAR;
         return r;
      end
      if (d2 < diff * diff) begin
         r.status = STATUS_TOO_CLOSE;
         return r;
      end
      den = 2 * l1 * l2;
      if (den == 0) c = UNIT_C;
      else begin
         num = d2 - l1 * l1 - l2 * l2;
         mag = (num < 0) ? -num : num;
         q = (mag <<< 14) / den;
         if (q > UNIT_C) q = UNIT_C;
         c = (num < 0) ? -q : q;
      end
      s = isqrt(UNIT_C * UNIT_C - c * c);
      if (ch == CHOICE_UP) up = 1'b1;
      else if (ch == CHOICE_DOWN) up = 1'b0;
      else up = (y < 0);
      q2 = vector_angle(s * 1024, c * 1024);
      k1 = l1 * UNIT_C + l2 * c;
      k2 = l2 * s;
      if (!up) begin
         q2 = -q2;
         k2 = -k2;
      end
      q1 = vector_angle(y * UNIT_C, x * UNIT_C) - vector_angle(k2, k1);
      while (q1 > HALF_TURN) q1 -= FULL_TURN;
      while (q1 <= -HALF_TURN) q1 += FULL_TURN;
      r.shoulder = joint_out(q1, offs_shoulder);
      r.elbow    = joint_out(q2, offs_elbow);
      r.status   = STATUS_SOLVED;
      return r;
   endfunction

   assign pending_count = cmd_queue.size();

   always @(posedge clock) begin
      joint_cmd_type want;
      if (reset) begin
         link_a <= FIRST_LINK_RESET;
         link_b <= SECOND_LINK_RESET;
         offs_shoulder <= SHOULDER_RESET;
         offs_elbow <= ELBOW_RESET;
         cmd_queue.delete();
         fail_count <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_FIRST_LINK:  link_a <= csr_wdata[LINK_W-1:0];
               REG_SECOND_LINK: link_b <= csr_wdata[LINK_W-1:0];
               REG_SHOULDER:    offs_shoulder <= csr_wdata;
               REG_ELBOW:       offs_elbow <= csr_wdata;
               default: ;
            endcase
         end
         if (start && !busy)
            cmd_queue.push_back(solve_joints(req_target_x, req_target_y, req_elbow_choice));
         if (rsp_valid) begin
            if (cmd_queue.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected result beat: shoulder %0d elbow %0d status %0d",
                     rsp_shoulder_angle, rsp_elbow_angle, rsp_status);
               fail_count <= fail_count + 1;
            end else begin
               want = cmd_queue.pop_front();
               if (want.shoulder !== rsp_shoulder_angle || want.elbow !== rsp_elbow_angle ||
                   want.status !== rsp_status) begin
                  if (fail_count < 10)
                     $display("mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                        want.shoulder, want.elbow, want.status,
                        rsp_shoulder_angle, rsp_elbow_angle, rsp_status);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

@@ verif/two_link_inverse_kinematics_unit_tb.sv @@
// testbench top of the two-link ik unit: stimulus, register phases and verdict
`timescale 1ns / 1ps
module two_link_inverse_kinematics_unit_tb import tlik_pkg::*;;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic signed [COORD_W-1:0] req_target_x = '0;
   logic signed [COORD_W-1:0] req_target_y = '0;
   logic [CHOICE_W-1:0]       req_elbow_choice = '0;
   logic                      rsp_valid;
   logic signed [ANGLE_W-1:0] rsp_shoulder_angle, rsp_elbow_angle;
   logic [1:0]                rsp_status;
   logic                      csr_we = 1'b0;
   logic [INDEX_W-1:0]        csr_index = '0;
   logic [ANGLE_W-1:0]        csr_wdata = '0;
   int                        fail_count, pending_count;
   int                        quiet_cycles = 0;
   int                        reach;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   two_link_inverse_kinematics_unit i_dut (.*);
   two_link_inverse_kinematics_unit_checker i_checker (.*);

   // watchdog on cycles with no beat in either direction
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || reset) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 5000) begin
         $display("two_link_inverse_kinematics_unit test failed");
         $finish;
      end
   end

   task automatic send_target(logic [15:0] x, logic [15:0] y, logic [1:0] ch);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
      if ($urandom_range(0, 1) == 0) gap = 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_target_x <= x;
      req_target_y <= y;
      req_elbow_choice <= ch;
      @(negedge clock);
      while (busy) @(negedge clock);
      @(posedge clock);
   endtask

   // drain the pipe, then write one register
   task automatic write_reg(logic [INDEX_W-1:0] idx, logic [15:0] val);
      start <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_links(logic [15:0] a, logic [15:0] b, logic [15:0] so, logic [15:0] eo);
      write_reg(REG_FIRST_LINK, a);
      write_reg(REG_SECOND_LINK, b);
      write_reg(REG_SHOULDER, so);
      write_reg(REG_ELBOW, eo);
      reach = a[13:0] + b[13:0];
      if (reach > 32767) reach = 32767;
      if (reach == 0) reach = 1;
   endtask

   task automatic random_targets(int n);
      int x, y;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 9) < 7) begin
            x = $urandom_range(0, 2 * reach) - reach;
            y = $urandom_range(0, 2 * reach) - reach;
            send_target(16'(x), 16'(y), 2'($urandom_range(0, 3)));
         end else begin
            send_target(16'($urandom), 16'($urandom), 2'($urandom_range(0, 3)));
         end
      end
   endtask

   initial begin
      reach = 3584 + 4506;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: extremes, each elbow choice, reach failures
      send_target(16'h0000, 16'h0000, 2'd0);
      send_target(16'h8000, 16'h8000, 2'd0);
      send_target(16'h7fff, 16'h7fff, 2'd1);
      send_target(16'h8000, 16'h7fff, 2'd2);
      send_target(16'd8090, 16'd0, 2'd0);
      send_target(16'd922, 16'd0, 2'd1);
      send_target(16'd5000, 16'd3000, 2'd0);
      send_target(16'd5000, -16'sd3000, 2'd0);
      send_target(-16'sd5000, 16'd3000, 2'd1);
      send_target(-16'sd5000, -16'sd3000, 2'd2);
      send_target(16'd0, 16'd6000, 2'd3);
      send_target(-16'sd6000, 16'd0, 2'd3);
      random_targets(300);
      // equal links: the origin is reachable with the elbow folded
      set_links(16'd4000, 16'd4000, 16'd0, 16'd0);
      send_target(16'd0, 16'd0, 2'd1);
      send_target(16'd0, 16'd0, 2'd2);
      send_target(16'd8000, 16'd0, 2'd0);
      random_targets(300);
      // zero first link: cosine taken as one
      set_links(16'd0, 16'd5000, 16'h5a00, 16'ha600);
      send_target(16'd5000, 16'd0, 2'd0);
      send_target(16'd0, -16'sd5000, 2'd0);
      random_targets(250);
      // longest links, offsets at the ends of their range
      set_links(16'h3fff, 16'h3fff, 16'h8000, 16'h7fff);
      send_target(16'h8000, 16'h8000, 2'd1);
      send_target(16'h7fff, 16'h0000, 2'd2);
      random_targets(300);
      set_links(16'hffff, 16'd1, 16'hffff, 16'h8000);
      random_targets(250);
      set_links(16'd1024, 16'd2048, 16'd0, 16'd23040);
      random_targets(300);
      set_links(16'd3584, 16'd4506, 16'd1792, 16'd3200);
      random_targets(100);
      start <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (fail_count == 0)
         $display("two_link_inverse_kinematics_unit test passed");
      else
         $display("two_link_inverse_kinematics_unit test failed");
      $finish;
   end

endmodule
